FILE: sv/aes128_counter_mode_cipher_assert.svh
// Assertion macros for the AES-128 counter-mode cipher
`ifndef AES128_COUNTER_MODE_CIPHER_ASSERT_SVH
`define AES128_COUNTER_MODE_CIPHER_ASSERT_SVH

`define ACMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ACMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/acmc_pkg.sv
`default_nettype none
package acmc_pkg;
    localparam int KeyWords  = 44;
    localparam int BlockBytes = 16;
    localparam int QueueDepth = 4;

    typedef enum logic [1:0] {
        REG_KEY_UPPER = 2'd0,
        REG_KEY_LOWER = 2'd1,
        REG_IV_UPPER  = 2'd2,
        REG_IV_LOWER  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic         valid;
        logic [127:0] block;
    } t_ks_block;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        unique case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the state sits at bits 127-8i
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127 - 8 * (c * 4 + r) -: 8] = sbox(s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]);
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3, h;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            h  = a0 ^ a1 ^ a2 ^ a3;
            o[127 - 32 * c -: 8] = a0 ^ h ^ xt(a0 ^ a1);
            o[119 - 32 * c -: 8] = a1 ^ h ^ xt(a1 ^ a2);
            o[111 - 32 * c -: 8] = a2 ^ h ^ xt(a2 ^ a3);
            o[103 - 32 * c -: 8] = a3 ^ h ^ xt(a3 ^ a0);
        end
        return o;
    endfunction

    function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [3:0] r);
        logic [31:0] t, w0, w1, w2, w3;
        t  = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])} ^ {rcon(r), 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction
endpackage
`default_nettype wire

FILE: sv/acmc_engine.sv
`default_nettype none
module acmc_engine (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_restart,
    input  wire logic [127:0]         i_key,
    input  wire logic [127:0]         i_iv,
    input  wire logic                 i_space,
    output acmc_pkg::t_ks_block       o_blk
);
    import acmc_pkg::*;

    typedef enum logic [1:0] {S_LOAD, S_ROUND, S_PUSH} t_state;

    t_state       r_state;
    logic [3:0]   r_round;
    logic [127:0] r_ctr;
    logic [127:0] r_st;
    logic [127:0] r_rk;
    logic [127:0] n_rk;
    logic [127:0] n_ss;
    logic [127:0] n_st;

    always_comb begin
        n_rk = next_rkey(r_rk, r_round);
        n_ss = sub_shift(r_st);
        n_st = ((r_round == 4'd10) ? n_ss : mix_cols(n_ss)) ^ n_rk;
    end

    always_ff @(posedge i_clk) begin
        o_blk.valid <= 1'b0;
        if (!i_rst_n || i_restart) begin
            r_state <= S_LOAD;
            r_round <= 4'd1;
            r_ctr   <= i_iv;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    r_st    <= r_ctr ^ i_key;
                    r_rk    <= i_key;
                    r_round <= 4'd1;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_st    <= n_st;
                    r_rk    <= n_rk;
                    r_round <= r_round + 4'd1;
                    if (r_round == 4'd10) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (i_space) begin
                        o_blk.valid <= 1'b1;
                        r_ctr       <= r_ctr + 128'd1;
                        r_state     <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
        o_blk.block <= r_st;
    end
endmodule
`default_nettype wire

FILE: sv/acmc_front.sv
`default_nettype none
module acmc_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_restart,
    input  acmc_pkg::t_ks_block       i_blk,
    output logic                      o_space,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           i_data_in,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [7:0]                o_data_out
);
    import acmc_pkg::*;

    logic [127:0] r_q [QueueDepth];
    logic [1:0]   r_wp, r_rp;
    logic [2:0]   r_cnt;
    logic [3:0]   r_pos;
    logic [1:0]   r_ocnt;
    logic [7:0]   r_ob [2];
    logic         r_ow, r_or;
    logic         take, give, use_blk;
    logic [7:0]   ks;

    assign o_space = (r_cnt < 3'd3);
    assign full    = (r_cnt == 3'd0) || (r_ocnt == 2'd2);
    assign empty   = (r_ocnt == 2'd0);
    assign take    = push && !full;
    assign give    = pop && !empty;
    assign use_blk = take && (r_pos == 4'd15);
    assign ks      = r_q[r_rp][127 - 8 * r_pos -: 8];
    assign o_data_out = r_ob[r_or];

    always_ff @(posedge i_clk) begin
        if (i_blk.valid) begin
            r_q[r_wp] <= i_blk.block;
        end
        if (take) begin
            r_ob[r_ow] <= i_data_in ^ ks;
        end
        if (!i_rst_n || i_restart) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_pos <= '0;
        end else begin
            if (i_blk.valid) r_wp <= r_wp + 2'd1;
            if (use_blk) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, i_blk.valid} - {2'b0, use_blk};
            if (take) r_pos <= r_pos + 4'd1;
        end
        if (!i_rst_n) begin
            r_ow <= 1'b0; r_or <= 1'b0; r_ocnt <= '0;
        end else begin
            if (take) r_ow <= ~r_ow;
            if (give) r_or <= ~r_or;
            r_ocnt <= r_ocnt + {1'b0, take} - {1'b0, give};
        end
    end
endmodule
`default_nettype wire

FILE: sv/aes128_counter_mode_cipher.sv
// AES-128 counter-mode byte cipher.
// Configuration: write key_upper (0), key_lower (1), iv_upper (2), iv_lower (3)
// through cfg_valid/cfg_ready with i_cfg_index and i_cfg_data; writes to other
// indexes are dropped. Any valid write reloads the counter and drops all
// prefetched keystream; write only while idle.
// Input: push/full, one byte per item. Output: empty/pop, one byte per item.
// A back engine runs one AES round per cycle and prefetches keystream blocks
// into a three-block queue; the front XORs one byte per cycle, while full is
// low, with the oldest block. Empty goes low in the cycle after an item is
// accepted. Sustained rate: one byte per cycle while the receiver pops; a
// block lasts 16 bytes, longer than the engine takes to make one.
// After reset or a write, full stays high until the first block arrives.
// Reset clears the configuration to a zero key and zero IV.
// When the receiver stalls, a two-entry result buffer fills and full rises;
// no item is lost.
`default_nettype none
module aes128_counter_mode_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_in,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_data_out,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    import acmc_pkg::*;

    logic [63:0] r_cfg [4];
    logic        r_restart;
    logic        wr;
    t_ks_block   blk;
    logic        space;

    assign cfg_ready = 1'b1;
    assign wr = cfg_valid && (i_cfg_index[63:2] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= '0; r_cfg[1] <= '0; r_cfg[2] <= '0; r_cfg[3] <= '0;
            r_restart <= 1'b0;
        end else begin
            r_restart <= wr;
            if (wr) r_cfg[i_cfg_index[1:0]] <= i_cfg_data;
        end
    end

    acmc_engine u_engine (
        .i_clk, .i_rst_n, .i_restart(r_restart || wr),
        .i_key({r_cfg[REG_KEY_UPPER], r_cfg[REG_KEY_LOWER]}),
        .i_iv({r_cfg[REG_IV_UPPER], r_cfg[REG_IV_LOWER]}),
        .i_space(space), .o_blk(blk)
    );

    acmc_front u_front (
        .i_clk, .i_rst_n, .i_restart(r_restart || wr), .i_blk(blk), .o_space(space),
        .push, .full, .i_data_in, .empty, .pop, .o_data_out
    );
endmodule
`default_nettype wire

FILE: sv/acmc_checker.sv
`default_nettype none
`include "aes128_counter_mode_cipher_assert.svh"
module acmc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_data_out
);
    `ACMC_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, push && !full, !empty)
    `ACMC_ASSERT_NXT(a_hold_data, i_clk, i_rst_n, !empty && !pop, $stable(o_data_out) && !empty)
    `ACMC_ASSERT_NXT(a_idle_drain, i_clk, i_rst_n, !(push && !full) && empty, empty)
endmodule

bind aes128_counter_mode_cipher acmc_checker u_checker (
    .i_clk, .i_rst_n, .push, .full, .empty, .pop, .o_data_out
);
`default_nettype wire
